>>> rtl/maf_pkg.sv
// ----------------------------------------------------------------------------
// maf_pkg
// Shared types, constants and AES helpers for the MILENAGE engine.
// ----------------------------------------------------------------------------
package maf_pkg;

    localparam int BlockW = 128;

    typedef enum logic [1:0] {
        ACT_GEN    = 2'd0,
        ACT_OPC    = 2'd1,
        ACT_RESYNC = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // AES core control, sequencer to core
    typedef struct packed {
        logic start;
    } aes_ctrl_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block, byte 0 in the top bits
    function automatic logic [7:0] byte_of(input logic [BlockW-1:0] b, input int i);
        return b[BlockW-1-8*i -: 8];
    endfunction

    // out byte (i+n)%16 = in byte i; byte 0 sits in the top bits, so this
    // moves bytes toward the low end
    function automatic logic [BlockW-1:0] rot_bytes(input logic [BlockW-1:0] b,
                                                    input int n);
        return (b >> (8*n)) | (b << (BlockW-8*n));
    endfunction

endpackage

>>> rtl/milenage_auth_functions_unit.sv
// ----------------------------------------------------------------------------
// milenage_auth_functions_unit
// MILENAGE f1..f5* and OPc derivation on one shared AES-128 core.
// ----------------------------------------------------------------------------
// One transaction in, one result out. Each AES pass has a load step
// (ST_START), ten rounds in the core, a wait in ST_WAIT until the core's done
// flag is seen and a step to the next pass in ST_NEXT (the last pass skips
// the step). Generate runs six passes, resync three, OPc one, the unused
// action code two. tready is low from acceptance until the result is taken,
// and the block passes through idle, where tready is high, before it can
// take the next one.
module milenage_auth_functions_unit
    import maf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // key_hi, key_lo, opc_hi, opc_lo, rand_hi, rand_lo, sqn, amf, mac_s_in
    input  logic [511:0] s_tdata,
    input  logic [1:0]   s_tuser,     // action
    output logic         m_tvalid,
    input  logic         m_tready,
    // mac_a, mac_s, res, ck_or_opc_hi, ck_or_opc_lo, ik_hi, ik_lo, ak,
    // ak_resync, sqn_ms, resync_ok, zero pad
    output logic [599:0] m_tdata
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_START = 5'b00010,
        ST_WAIT  = 5'b00100,
        ST_NEXT  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t            st_reg, st_next;
    logic [2:0]        pass_reg, pass_next;
    action_t           act_reg;
    logic [BlockW-1:0] key_reg, opc_reg, rand_reg, temp_reg;
    logic [47:0]       sqn_reg, ak_reg, aks_reg, sms_reg;
    logic [15:0]       amf_reg;
    logic [63:0]       macin_reg, maca_reg, macs_reg, res_reg;
    logic [BlockW-1:0] ck_reg, ik_reg;
    logic              ok_reg;
    aes_ctrl_t         ctrl;
    logic              done;
    logic [BlockW-1:0] din, dout, outx, tx, in1;
    logic [47:0]       sqn1;
    logic [15:0]       amf1;
    logic              last;

    // pass order: 0 TEMP, 1 OUT5, 2 OUT1, 3 OUT2, 4 OUT3, 5 OUT4
    assign tx   = temp_reg ^ opc_reg;
    assign sqn1 = (act_reg == ACT_RESYNC) ? sms_reg : sqn_reg;
    assign amf1 = (act_reg == ACT_RESYNC) ? 16'd0 : amf_reg;
    assign in1  = {sqn1, amf1, sqn1, amf1};
    always_comb
    begin
        case (pass_reg)
            3'd0:    din = (act_reg == ACT_OPC) ? opc_reg : rand_reg ^ opc_reg;
            3'd1:    din = rot_bytes(tx, 4) ^ 128'h8;
            3'd2:    din = temp_reg ^ rot_bytes(in1 ^ opc_reg, 8);
            3'd3:    din = tx ^ 128'h1;
            3'd4:    din = rot_bytes(tx, 12) ^ 128'h2;
            default: din = rot_bytes(tx, 8) ^ 128'h4;
        endcase
    end

    assign outx = dout ^ opc_reg;
    always_comb
    begin
        case (act_reg)
            ACT_OPC:    last = 1'b1;
            ACT_RESYNC: last = (pass_reg == 3'd2);
            ACT_NONE:   last = (pass_reg == 3'd1);
            default:    last = (pass_reg == 3'd5);
        endcase
    end

    assign ctrl.start = (st_reg == ST_START);

    maf_aes_core u_aes (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (ctrl),
        .key  (key_reg),
        .din  (din),
        .done (done),
        .dout (dout)
    );

    always_comb
    begin
        st_next   = st_reg;
        pass_next = pass_reg;
        unique case (st_reg)
            ST_IDLE:  if (s_tvalid) st_next = ST_START;
            ST_START: st_next = ST_WAIT;
            ST_WAIT:  if (done) st_next = last ? ST_OUT : ST_NEXT;
            ST_NEXT:
            begin
                pass_next = pass_reg + 3'd1;
                st_next   = ST_START;
            end
            ST_OUT:   if (m_tready) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
        if (st_reg == ST_IDLE)
            pass_next = 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            pass_reg <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            pass_reg <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && s_tvalid)
        begin
            act_reg   <= action_t'(s_tuser);
            key_reg   <= {s_tdata[63:0], s_tdata[127:64]};
            opc_reg   <= {s_tdata[191:128], s_tdata[255:192]};
            rand_reg  <= {s_tdata[319:256], s_tdata[383:320]};
            sqn_reg   <= s_tdata[431:384];
            amf_reg   <= s_tdata[447:432];
            macin_reg <= s_tdata[511:448];
            maca_reg  <= '0;
            macs_reg  <= '0;
            res_reg   <= '0;
            ck_reg    <= '0;
            ik_reg    <= '0;
            ak_reg    <= '0;
            aks_reg   <= '0;
            sms_reg   <= '0;
            ok_reg    <= 1'b0;
        end
        else if (st_reg == ST_WAIT && done && act_reg != ACT_NONE)
        begin
            case (pass_reg)
                3'd0:
                    if (act_reg == ACT_OPC)
                        ck_reg <= dout ^ opc_reg;
                    else
                        temp_reg <= dout;
                3'd1:
                begin
                    aks_reg <= outx[127:80];
                    if (act_reg == ACT_RESYNC)
                        sms_reg <= sqn_reg ^ outx[127:80];
                end
                3'd2:
                begin
                    macs_reg <= outx[63:0];
                    if (act_reg == ACT_RESYNC)
                        ok_reg <= (outx[63:0] == macin_reg);
                    else
                        maca_reg <= outx[127:64];
                end
                3'd3:
                begin
                    res_reg <= outx[63:0];
                    ak_reg  <= outx[127:80];
                end
                3'd4:    ck_reg <= outx;
                default: ik_reg <= outx;
            endcase
        end
    end

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = (st_reg == ST_OUT);
    assign m_tdata  = {7'd0, ok_reg, sms_reg, aks_reg, ak_reg, ik_reg[63:0],
                       ik_reg[127:64], ck_reg[63:0], ck_reg[127:64], res_reg,
                       macs_reg, maca_reg};

endmodule

>>> rtl/maf_aes_core.sv
// ----------------------------------------------------------------------------
// maf_aes_core
// AES-128 encrypt, one round per cycle, round key expanded on the fly.
// ----------------------------------------------------------------------------
module maf_aes_core
    import maf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  aes_ctrl_t         ctrl,
    input  logic [BlockW-1:0] key,
    input  logic [BlockW-1:0] din,
    output logic              done,
    output logic [BlockW-1:0] dout
);

    logic [BlockW-1:0] state_reg, state_next;
    logic [BlockW-1:0] rkey_reg, rkey_next;
    logic [7:0]        rc_reg, rc_next;
    logic [3:0]        round_reg, round_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [BlockW-1:0] sr, mc;

    // key schedule step from the current round key
    always_comb
    begin
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t  = {sbox(rkey_reg[23:16]) ^ rc_reg, sbox(rkey_reg[15:8]),
              sbox(rkey_reg[7:0]), sbox(rkey_reg[31:24])};
        w0 = rkey_reg[127:96] ^ t;
        w1 = rkey_reg[95:64] ^ w0;
        w2 = rkey_reg[63:32] ^ w1;
        w3 = rkey_reg[31:0] ^ w2;
        rkey_next = {w0, w1, w2, w3};
    end

    // subbytes + shiftrows; byte index r + 4c
    always_comb
    begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                sr[BlockW-1-8*(r+4*c) -: 8] =
                    sbox(byte_of(state_reg, r + 4*((c + r) % 4)));
    end

    always_comb
    begin
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++)
        begin
            a0 = byte_of(sr, 4*c);
            a1 = byte_of(sr, 4*c+1);
            a2 = byte_of(sr, 4*c+2);
            a3 = byte_of(sr, 4*c+3);
            al = a0 ^ a1 ^ a2 ^ a3;
            mc[BlockW-1-32*c -: 32] = {a0 ^ al ^ xt(a0 ^ a1), a1 ^ al ^ xt(a1 ^ a2),
                                       a2 ^ al ^ xt(a2 ^ a3), a3 ^ al ^ xt(a3 ^ a0)};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        rc_next    = rc_reg;
        done_next  = 1'b0;
        if (ctrl.start)
        begin
            state_next = din ^ key;
            busy_next  = 1'b1;
            round_next = 4'd1;
            rc_next    = 8'h01;
        end
        else if (busy_reg)
        begin
            state_next = ((round_reg == 4'd10) ? sr : mc) ^ rkey_next;
            rc_next    = xt(rc_reg);
            round_next = round_reg + 4'd1;
            if (round_reg == 4'd10)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
            rc_reg    <= 8'h01;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            round_reg <= round_next;
            rc_reg    <= rc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        if (ctrl.start)
            rkey_reg <= key;
        else if (busy_reg)
            rkey_reg <= rkey_next;
    end

    assign done = done_reg;
    assign dout = state_reg;

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for milenage_auth_functions_unit. A directed table runs
// first, then random generate / OPc / resync / unused-action requests with bursty input and a
// stalling output. Expected results come from a local MILENAGE/AES model.
// ----------------------------------------------------------------------------
module tb;
    import maf_pkg::*;

    typedef struct packed {
        action_t      act;
        logic [63:0]  key_hi;
        logic [63:0]  key_lo;
        logic [63:0]  opc_hi;
        logic [63:0]  opc_lo;
        logic [63:0]  rand_hi;
        logic [63:0]  rand_lo;
        logic [47:0]  sqn;
        logic [15:0]  amf;
        logic [63:0]  mac_s_in;
    } auth_req_t;

    typedef struct packed {
        logic [63:0] mac_a;
        logic [63:0] mac_s;
        logic [63:0] res;
        logic [63:0] ck_hi;
        logic [63:0] ck_lo;
        logic [63:0] ik_hi;
        logic [63:0] ik_lo;
        logic [47:0] ak;
        logic [47:0] ak_star;
        logic [47:0] sqn_ms;
        logic        resync_ok;
    } auth_res_t;

    typedef struct {
        auth_req_t req;
        logic      fixed;     // expected result is all zeros
        logic      match_mac; // load mac_s_in with the correct MAC-S
    } stim_row_t;

    localparam int NumRandom = 1640;
    localparam int WatchLimit = 4000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // key_hi, key_lo, opc_hi, opc_lo, rand_hi, rand_lo, sqn, amf, mac_s_in
    logic [511:0] s_tdata;
    action_t      s_tuser;   // action
    logic         m_tvalid;
    logic         m_tready;
    logic [599:0] m_tdata;   // mac_a, mac_s, res, ck/opc hi, lo, ik hi, lo, ak, ak*, sqn_ms, ok

    logic [7:0]   sb [0:255];
    auth_res_t    vec_q[$];
    int           err_cnt;
    int           idle_cycles;

    milenage_auth_functions_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // AES-128 / MILENAGE model
    // ------------------------------------------------------------------
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[0])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return p;
    endfunction

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes128(input logic [127:0] k, input logic [127:0] pt);
        logic [7:0] w [0:175];
        logic [7:0] s [0:15];
        logic [7:0] t [0:15];
        logic [7:0] rc, t0, t1, t2, t3, u, a0, a1, a2, a3, all;
        logic [127:0] ct;
        rc = 8'h01;
        for (int i = 0; i < 16; i++)
            w[i] = k[127-8*i -: 8];
        for (int i = 16; i < 176; i += 4)
        begin
            t0 = w[i-4]; t1 = w[i-3]; t2 = w[i-2]; t3 = w[i-1];
            if ((i % 16) == 0)
            begin
                u  = t0;
                t0 = sb[t1] ^ rc;
                t1 = sb[t2];
                t2 = sb[t3];
                t3 = sb[u];
                rc = dbl(rc);
            end
            w[i]   = w[i-16] ^ t0;
            w[i+1] = w[i-15] ^ t1;
            w[i+2] = w[i-14] ^ t2;
            w[i+3] = w[i-13] ^ t3;
        end
        for (int i = 0; i < 16; i++)
            s[i] = pt[127-8*i -: 8] ^ w[i];
        for (int rd = 1; rd <= 10; rd++)
        begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    t[r+4*c] = sb[s[r+4*((c+r)%4)]];
            if (rd != 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ all ^ dbl(a0 ^ a1);
                    t[4*c+1] = a1 ^ all ^ dbl(a1 ^ a2);
                    t[4*c+2] = a2 ^ all ^ dbl(a2 ^ a3);
                    t[4*c+3] = a3 ^ all ^ dbl(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                s[i] = t[i] ^ w[16*rd+i];
        end
        for (int i = 0; i < 16; i++)
            ct[127-8*i -: 8] = s[i];
        return ct;
    endfunction

    // OUT2..OUT5: byte i of TEMP^OPc lands at byte (i+sh)%16, constant into last byte
    function automatic logic [127:0] out_n(input logic [127:0] k, input logic [127:0] tmp,
                                           input logic [127:0] opc, input int sh,
                                           input logic [7:0] cst);
        logic [127:0] y, x;
        y = tmp ^ opc;
        for (int i = 0; i < 16; i++)
            x[127-8*((i+sh)%16) -: 8] = y[127-8*i -: 8];
        x[7:0] ^= cst;
        return aes128(k, x) ^ opc;
    endfunction

    function automatic logic [127:0] out_f1(input logic [127:0] k, input logic [127:0] tmp,
                                            input logic [127:0] opc, input logic [47:0] sqn,
                                            input logic [15:0] amf);
        logic [127:0] y;
        y = {sqn, amf, sqn, amf} ^ opc;
        return aes128(k, {y[63:0], y[127:64]} ^ tmp) ^ opc;
    endfunction

    function automatic auth_res_t milenage(input auth_req_t r);
        auth_res_t    e;
        logic [127:0] k, opc, tmp, o;
        e = '0;
        k = {r.key_hi, r.key_lo};
        opc = {r.opc_hi, r.opc_lo};
        if (r.act == ACT_OPC)
        begin
            o = aes128(k, opc) ^ opc;
            {e.ck_hi, e.ck_lo} = o;
        end
        else if (r.act != ACT_NONE)
        begin
            tmp = aes128(k, {r.rand_hi, r.rand_lo} ^ opc);
            o = out_n(k, tmp, opc, 4, 8'h08);
            e.ak_star = o[127:80];
            if (r.act == ACT_RESYNC)
            begin
                e.sqn_ms = r.sqn ^ e.ak_star;
                o = out_f1(k, tmp, opc, e.sqn_ms, 16'h0000);
                e.mac_s = o[63:0];
                e.resync_ok = (e.mac_s == r.mac_s_in);
            end
            else
            begin
                o = out_f1(k, tmp, opc, r.sqn, r.amf);
                {e.mac_a, e.mac_s} = o;
                o = out_n(k, tmp, opc, 0, 8'h01);
                e.res = o[63:0];
                e.ak = o[127:80];
                {e.ck_hi, e.ck_lo} = out_n(k, tmp, opc, 12, 8'h02);
                {e.ik_hi, e.ik_lo} = out_n(k, tmp, opc, 8, 8'h04);
            end
        end
        return e;
    endfunction

    // S-box from GF(2^8) inverse plus affine map
    initial
    begin
        logic [7:0] inv, s;
        for (int a = 0; a < 256; a++)
        begin
            inv = 8'h00;
            for (int b = 1; b < 256; b++)
                if (gf_mul(a[7:0], b[7:0]) == 8'h01)
                    inv = b[7:0];
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sb[a] = s;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic logic [511:0] pack_req(input auth_req_t r);
        logic [511:0] v;
        v = '0;
        v[63:0]    = r.key_hi;
        v[127:64]  = r.key_lo;
        v[191:128] = r.opc_hi;
        v[255:192] = r.opc_lo;
        v[319:256] = r.rand_hi;
        v[383:320] = r.rand_lo;
        v[431:384] = r.sqn;
        v[447:432] = r.amf;
        v[511:448] = r.mac_s_in;
        return v;
    endfunction

    function automatic logic [63:0] rnd64();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic auth_req_t mk(input action_t a, input logic [63:0] kh, kl, oh, ol,
                                     rh, rl, input logic [47:0] sq, input logic [15:0] af,
                                     input logic [63:0] mc);
        auth_req_t r;
        r.act = a; r.key_hi = kh; r.key_lo = kl; r.opc_hi = oh; r.opc_lo = ol;
        r.rand_hi = rh; r.rand_lo = rl; r.sqn = sq; r.amf = af; r.mac_s_in = mc;
        return r;
    endfunction

    localparam logic [63:0] Z = 64'h0;
    localparam logic [63:0] F = '1;
    localparam logic [63:0] A5 = 64'haaaa_5555_aaaa_5555;

    stim_row_t rows [0:14];
    int        burst_left;

    initial
    begin
        rows[0]  = '{mk(ACT_GEN, Z, Z, Z, Z, Z, Z, '0, '0, Z), 1'b0, 1'b0};
        rows[1]  = '{mk(ACT_OPC, Z, Z, Z, Z, Z, Z, '0, '0, Z), 1'b0, 1'b0};
        rows[2]  = '{mk(ACT_RESYNC, Z, Z, Z, Z, Z, Z, '0, '0, Z), 1'b0, 1'b0};
        rows[3]  = '{mk(ACT_NONE, Z, Z, Z, Z, Z, Z, '0, '0, Z), 1'b1, 1'b0};
        rows[4]  = '{mk(ACT_GEN, F, F, F, F, F, F, '1, '1, F), 1'b0, 1'b0};
        rows[5]  = '{mk(ACT_OPC, F, F, F, F, F, F, '1, '1, F), 1'b0, 1'b0};
        rows[6]  = '{mk(ACT_RESYNC, F, F, F, F, F, F, '1, '1, F), 1'b0, 1'b0};
        rows[7]  = '{mk(ACT_NONE, F, F, F, F, F, F, '1, '1, F), 1'b1, 1'b0};
        rows[8]  = '{mk(ACT_GEN, F, F, Z, Z, Z, Z, '1, '0, Z), 1'b0, 1'b0};
        rows[9]  = '{mk(ACT_GEN, Z, Z, A5, ~A5, Z, F, '0, '1, Z), 1'b0, 1'b0};
        // resync where the received MAC-S is genuine, then one bit off
        rows[10] = '{mk(ACT_RESYNC, A5, ~A5, F, Z, A5, Z, 48'h1234_5678_9abc, 16'hbeef, Z),
                     1'b0, 1'b1};
        rows[11] = '{mk(ACT_RESYNC, F, Z, A5, A5, Z, F, '1, '0, Z), 1'b0, 1'b1};
        rows[12] = '{mk(ACT_OPC, 64'h465b5ce8b199b49f, 64'haa5f0a2ee238a6bc,
                        64'hcdc202d5123e20f6, 64'h2b6d676ac72cb318, Z, Z, '0, '0, Z),
                     1'b0, 1'b0};
        rows[13] = '{mk(ACT_GEN, 64'h465b5ce8b199b49f, 64'haa5f0a2ee238a6bc,
                        64'hcd63cb71954a9f4e, 64'h48a5994e37a02baf,
                        64'h23553cbe9637a89d, 64'h218ae64dae47bf35,
                        48'hff9bb4d0b607, 16'hb9b9, Z), 1'b0, 1'b0};
        rows[14] = '{mk(ACT_NONE, A5, Z, F, A5, Z, F, 48'h5555_aaaa_5555, 16'h8001, A5),
                     1'b1, 1'b0};
    end

    task automatic send(input auth_req_t r, input auth_res_t e);
        s_tdata  <= pack_req(r);
        s_tuser  <= r.act;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        vec_q.push_back(e);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 8);
        end
    endtask

    initial
    begin
        auth_req_t r;
        auth_res_t e;
        int        pick;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_GEN;
        burst_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            r = rows[i].req;
            if (rows[i].match_mac)
            begin
                e = milenage(r);
                r.mac_s_in = e.mac_s;
            end
            e = rows[i].fixed ? auth_res_t'('0) : milenage(r);
            if (rows[i].match_mac && rows[i].req.act == ACT_RESYNC && i == 11)
            begin
                r.mac_s_in[0] = ~r.mac_s_in[0];
                e = milenage(r);
            end
            send(r, e);
        end

        for (int n = 0; n < NumRandom; n++)
        begin
            if (n == NumRandom / 2)
            begin
                // let the block drain completely before carrying on
                s_tvalid <= 1'b0;
                wait (vec_q.size() == 0);
                @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            r = mk(pick < 40 ? ACT_GEN : pick < 60 ? ACT_OPC : pick < 96 ? ACT_RESYNC : ACT_NONE,
                   rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(),
                   48'(rnd64()), 16'(rnd64()), rnd64());
            if (r.act == ACT_RESYNC && $urandom_range(0, 1))
            begin
                e = milenage(r);
                r.mac_s_in = e.mac_s;
            end
            send(r, milenage(r));
        end
        s_tvalid <= 1'b0;

        wait (vec_q.size() == 0);
        repeat (100) @(posedge clk);
        if (err_cnt == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    int stall_phase;

    task automatic cmp(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    initial
    begin
        err_cnt = 0;
        m_tready = 1'b0;
        stall_phase = 0;
    end

    always @(posedge clk)
    begin
        auth_res_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (vec_q.size() == 0)
            begin
                $error("result transaction with nothing expected");
                err_cnt++;
            end
            else
            begin
                e = vec_q.pop_front();
                cmp("mac_a", e.mac_a, m_tdata[63:0]);
                cmp("mac_s", e.mac_s, m_tdata[127:64]);
                cmp("res", e.res, m_tdata[191:128]);
                cmp("ck_or_opc_hi", e.ck_hi, m_tdata[255:192]);
                cmp("ck_or_opc_lo", e.ck_lo, m_tdata[319:256]);
                cmp("ik_hi", e.ik_hi, m_tdata[383:320]);
                cmp("ik_lo", e.ik_lo, m_tdata[447:384]);
                cmp("ak", 64'(e.ak), 64'(m_tdata[495:448]));
                cmp("ak_resync", 64'(e.ak_star), 64'(m_tdata[543:496]));
                cmp("sqn_ms", 64'(e.sqn_ms), 64'(m_tdata[591:544]));
                cmp("resync_ok", 64'(e.resync_ok), 64'(m_tdata[592]));
            end
        end
        // stall pattern: stretches always ready, random, and mostly stalled
        stall_phase <= (stall_phase + 1) % 3000;
        if (stall_phase < 1000)
            m_tready <= 1'b1;
        else if (stall_phase < 2000)
            m_tready <= $urandom_range(0, 1);
        else
            m_tready <= ($urandom_range(0, 5) == 0);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WatchLimit)
        begin
            $display("tb: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

>>> sim.f
rtl/maf_pkg.sv
rtl/maf_aes_core.sv
rtl/milenage_auth_functions_unit.sv
tb/sv/tb.sv
